// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the provisioning session checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define PSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Types, codes and constants of the provisioning session controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    localparam int TIME_BITS_DEF = 48;

    localparam int OUT_W      = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam int WIN_W   = 20;
    localparam int DELAY_W = 13;
    localparam int GRACE_W = 15;
    localparam int FAIL_W  = 5;
    localparam int REJ_W   = 32;

    localparam logic [WIN_W-1:0]   WIN_RST   = 20'd60000;
    localparam logic [DELAY_W-1:0] DELAY_RST = 13'd1000;
    localparam logic [GRACE_W-1:0] GRACE_RST = 15'd5000;
    localparam logic [FAIL_W-1:0]  LIMIT_RST = 5'd5;

    localparam logic [FAIL_W-1:0] FAIL_SAT = 5'd31;
    localparam int RETRY_GAP  = 2000;
    localparam int SETTLE_GAP = 500;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMMIT_DELAY = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRACE_LEN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAIL_LIMIT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLAIM_NEEDED = 3'd4;

    typedef enum logic [2:0] {
        EV_OPEN   = 3'd0,
        EV_APPLY  = 3'd1,
        EV_AUTH   = 3'd2,
        EV_POLL   = 3'd3,
        EV_ONLINE = 3'd4,
        EV_CLAIM  = 3'd5,
        EV_CLOSE  = 3'd6,
        EV_FAIL   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_BEGIN     = 3'd1,
        ACT_SOFTAP    = 3'd2,
        ACT_TRANSPORT = 3'd3,
        ACT_SUBMIT    = 3'd4,
        ACT_CLAIM     = 3'd5,
        ACT_STOP      = 3'd6
    } action_t;

    typedef enum logic [7:0] {
        MODE_CLOSED     = 8'b0000_0001,
        MODE_OPENING    = 8'b0000_0010,
        MODE_STARTING   = 8'b0000_0100,
        MODE_SERVING    = 8'b0000_1000,
        MODE_VALIDATING = 8'b0001_0000,
        MODE_GRACE      = 8'b0010_0000,
        MODE_LOCKED     = 8'b0100_0000,
        MODE_ERROR      = 8'b1000_0000
    } mode_t;

    // Mode codes as they appear on the result word.
    localparam logic [2:0] MC_CLOSED     = 3'd0;
    localparam logic [2:0] MC_OPENING    = 3'd1;
    localparam logic [2:0] MC_STARTING   = 3'd2;
    localparam logic [2:0] MC_SERVING    = 3'd3;
    localparam logic [2:0] MC_VALIDATING = 3'd4;
    localparam logic [2:0] MC_GRACE      = 3'd5;
    localparam logic [2:0] MC_LOCKED     = 3'd6;
    localparam logic [2:0] MC_ERROR      = 3'd7;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            MODE_CLOSED:     c = MC_CLOSED;
            MODE_OPENING:    c = MC_OPENING;
            MODE_STARTING:   c = MC_STARTING;
            MODE_SERVING:    c = MC_SERVING;
            MODE_VALIDATING: c = MC_VALIDATING;
            MODE_GRACE:      c = MC_GRACE;
            MODE_LOCKED:     c = MC_LOCKED;
            MODE_ERROR:      c = MC_ERROR;
            default:         c = MC_CLOSED;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/provisioning_session_controller.sv =====
// ----------------------------------------------------------------------------
// Provisioning session controller
// Timed onboarding session: one event word in, one action word out.
// ----------------------------------------------------------------------------
// Usage:
//   Events arrive on the s_ stream: s_tuser holds the event kind, s_tdata the
//   time stamp, status flags and rejection count. Every accepted event word
//   produces exactly one result word on the m_ stream: the action code and
//   the session mode after the event.
//   The configuration port writes one register per cycle with cfg_we high;
//   the user must see that registers are changed only while no event is in
//   flight; the block does not enforce this. An accepted word sits in the
//   input register while it is evaluated, and the result register then
//   loads the result unless the receiver stalls. Throughput is one event per
//   cycle while the receiver does not stall; the state update is a single
//   level of compares and adders, so back-to-back events chain without gaps.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more word; only then does s_tready drop.
//   Reset empties both registers, closes the session, clears all deadlines
//   and counters, and loads the configuration defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module provisioning_session_controller #(
    parameter int TIME_BITS = psc_pkg::TIME_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // now_time, onboarding_ready, access_point_up, link_online,
    // rejection_count, claim_ok, zero fill
    input  wire logic [((TIME_BITS + 36 + 7) / 8) * 8-1:0] s_tdata,
    // kind
    input  wire logic [2:0]                              s_tuser,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // action, mode_now, zero fill
    output logic [psc_pkg::OUT_W-1:0]                    m_tdata,
    input  wire logic                                    cfg_we,
    input  wire logic [psc_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

    localparam int TW     = TIME_BITS + 1;
    localparam int RDY_B  = TIME_BITS;
    localparam int AP_B   = TIME_BITS + 1;
    localparam int ONL_B  = TIME_BITS + 2;
    localparam int REJ_LO = TIME_BITS + 3;
    localparam int OK_B   = TIME_BITS + 3 + psc_pkg::REJ_W;

    // Configuration registers.
    logic [psc_pkg::WIN_W-1:0]   win_len_reg;
    logic [psc_pkg::DELAY_W-1:0] commit_delay_reg;
    logic [psc_pkg::GRACE_W-1:0] grace_len_reg;
    logic [psc_pkg::FAIL_W-1:0]  fail_limit_reg;
    logic                        claim_needed_reg;

    // Input register.
    logic                        in_vld_reg;
    logic [2:0]                  kind_reg;
    logic [TIME_BITS-1:0]        now_reg;
    logic                        ready_reg;
    logic                        ap_reg;
    logic                        online_reg;
    logic [psc_pkg::REJ_W-1:0]   rej_reg;
    logic                        ok_reg;

    // Session state.
    psc_pkg::mode_t              mode_reg, mode_next;
    logic [TW-1:0]               deadline_reg, deadline_next;
    logic [TW-1:0]               commit_reg, commit_next;
    logic [TW-1:0]               success_reg, success_next;
    logic [TW-1:0]               retry_reg, retry_next;
    logic [psc_pkg::FAIL_W-1:0]  fail_cnt_reg, fail_cnt_next;
    logic [psc_pkg::REJ_W-1:0]   snap_reg, snap_next;
    logic                        submitted_reg, submitted_next;
    logic                        claim_done_reg, claim_done_next;

    // Result register.
    logic                        out_vld_reg;
    psc_pkg::action_t            act_reg, act_next;
    logic [2:0]                  mode_code_reg;

    logic                        advance;
    logic                        in_fire;
    logic                        step;
    logic [TW-1:0]               t_ext;
    logic [TW-1:0]               sum_window;
    logic [TW-1:0]               sum_commit;
    logic [TW-1:0]               sum_grace;
    logic [TW-1:0]               sum_retry;
    logic [TW-1:0]               sum_settle;
    logic [psc_pkg::FAIL_W-1:0]  fail_inc;
    logic                        idle;
    logic                        end_sess;
    logic                        hold;
    psc_pkg::mode_t              end_mode;

    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;
    assign in_fire  = s_tvalid && s_tready;
    assign step     = in_vld_reg && advance;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, mode_code_reg, act_reg};

    assign t_ext      = {1'b0, now_reg};
    assign sum_window = t_ext + TW'(win_len_reg);
    assign sum_commit = t_ext + TW'(commit_delay_reg);
    assign sum_grace  = t_ext + TW'(grace_len_reg);
    assign sum_retry  = t_ext + TW'(psc_pkg::RETRY_GAP);
    assign sum_settle = t_ext + TW'(psc_pkg::SETTLE_GAP);
    assign fail_inc   = (fail_cnt_reg == psc_pkg::FAIL_SAT) ? fail_cnt_reg
                                                            : fail_cnt_reg + 5'd1;
    assign idle = (mode_reg == psc_pkg::MODE_CLOSED) || (mode_reg == psc_pkg::MODE_LOCKED)
               || (mode_reg == psc_pkg::MODE_ERROR);

    always_comb
    begin
        mode_next       = mode_reg;
        deadline_next   = deadline_reg;
        commit_next     = commit_reg;
        success_next    = success_reg;
        retry_next      = retry_reg;
        fail_cnt_next   = fail_cnt_reg;
        snap_next       = snap_reg;
        submitted_next  = submitted_reg;
        claim_done_next = claim_done_reg;
        act_next        = psc_pkg::ACT_NONE;
        end_sess        = 1'b0;
        end_mode        = psc_pkg::MODE_CLOSED;
        hold            = 1'b0;

        case (psc_pkg::kind_t'(kind_reg))
            psc_pkg::EV_OPEN:
            begin
                if (idle)
                begin
                    mode_next       = psc_pkg::MODE_OPENING;
                    deadline_next   = sum_window;
                    fail_cnt_next   = '0;
                    submitted_next  = 1'b0;
                    claim_done_next = 1'b0;
                    retry_next      = '0;
                    act_next        = psc_pkg::ACT_BEGIN;
                end
            end
            psc_pkg::EV_APPLY:
            begin
                if (mode_reg == psc_pkg::MODE_SERVING)
                begin
                    mode_next      = psc_pkg::MODE_VALIDATING;
                    snap_next      = rej_reg;
                    commit_next    = sum_commit;
                    submitted_next = 1'b0;
                end
            end
            psc_pkg::EV_AUTH:
            begin
                if (!idle)
                begin
                    fail_cnt_next = fail_inc;
                    if (fail_inc >= fail_limit_reg)
                    begin
                        end_sess = 1'b1;
                        end_mode = psc_pkg::MODE_LOCKED;
                    end
                end
            end
            psc_pkg::EV_POLL:
            begin
                if (!idle)
                begin
                    if (t_ext >= deadline_reg)
                    begin
                        end_sess = 1'b1;
                    end
                    else if (mode_reg == psc_pkg::MODE_OPENING && ready_reg)
                    begin
                        mode_next = psc_pkg::MODE_STARTING;
                        act_next  = psc_pkg::ACT_SOFTAP;
                    end
                    else if (mode_reg == psc_pkg::MODE_STARTING && ap_reg)
                    begin
                        mode_next = psc_pkg::MODE_SERVING;
                        act_next  = psc_pkg::ACT_TRANSPORT;
                    end
                    else if (mode_reg == psc_pkg::MODE_VALIDATING)
                    begin
                        if (!submitted_reg && t_ext >= commit_reg)
                        begin
                            submitted_next = 1'b1;
                            act_next       = psc_pkg::ACT_SUBMIT;
                        end
                        else if (rej_reg > snap_reg)
                        begin
                            mode_next      = psc_pkg::MODE_SERVING;
                            commit_next    = '0;
                            submitted_next = 1'b0;
                        end
                        else if (online_reg)
                        begin
                            mode_next = psc_pkg::MODE_GRACE;
                            if (claim_needed_reg)
                            begin
                                retry_next = sum_retry;
                                act_next   = psc_pkg::ACT_CLAIM;
                            end
                            else
                            begin
                                success_next = sum_grace;
                                // Grace of zero closes on the same poll.
                                hold = (grace_len_reg == '0);
                            end
                        end
                        end_sess = hold;
                    end
                    else if (mode_reg == psc_pkg::MODE_GRACE)
                    begin
                        if (claim_needed_reg && !claim_done_reg)
                        begin
                            if (t_ext >= retry_reg)
                            begin
                                retry_next = sum_retry;
                                act_next   = psc_pkg::ACT_CLAIM;
                            end
                        end
                        else if (t_ext >= success_reg)
                        begin
                            end_sess = 1'b1;
                        end
                    end
                end
            end
            psc_pkg::EV_ONLINE:
            begin
                if (mode_reg == psc_pkg::MODE_GRACE && (!claim_needed_reg || claim_done_reg))
                begin
                    success_next = sum_settle;
                end
            end
            psc_pkg::EV_CLAIM:
            begin
                if (mode_reg == psc_pkg::MODE_GRACE && claim_needed_reg && !claim_done_reg)
                begin
                    if (ok_reg)
                    begin
                        claim_done_next = 1'b1;
                        retry_next      = '0;
                        success_next    = sum_settle;
                    end
                    else
                    begin
                        retry_next = sum_retry;
                    end
                end
            end
            psc_pkg::EV_CLOSE:
            begin
                if (mode_reg != psc_pkg::MODE_CLOSED)
                begin
                    end_sess = 1'b1;
                end
            end
            psc_pkg::EV_FAIL:
            begin
                end_sess = 1'b1;
                end_mode = psc_pkg::MODE_ERROR;
            end
            default:
            begin
                act_next = psc_pkg::ACT_NONE;
            end
        endcase

        if (end_sess)
        begin
            mode_next       = end_mode;
            deadline_next   = '0;
            commit_next     = '0;
            success_next    = '0;
            retry_next      = '0;
            submitted_next  = 1'b0;
            claim_done_next = 1'b0;
            act_next        = psc_pkg::ACT_STOP;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg      <= psc_pkg::WIN_RST;
            commit_delay_reg <= psc_pkg::DELAY_RST;
            grace_len_reg    <= psc_pkg::GRACE_RST;
            fail_limit_reg   <= psc_pkg::LIMIT_RST;
            claim_needed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                psc_pkg::CFG_WINDOW_LEN:   win_len_reg      <= cfg_wdata[psc_pkg::WIN_W-1:0];
                psc_pkg::CFG_COMMIT_DELAY: commit_delay_reg <= cfg_wdata[psc_pkg::DELAY_W-1:0];
                psc_pkg::CFG_GRACE_LEN:    grace_len_reg    <= cfg_wdata[psc_pkg::GRACE_W-1:0];
                psc_pkg::CFG_FAIL_LIMIT:   fail_limit_reg   <= cfg_wdata[psc_pkg::FAIL_W-1:0];
                psc_pkg::CFG_CLAIM_NEEDED: claim_needed_reg <= cfg_wdata[0];
                default:                   claim_needed_reg <= claim_needed_reg;
            endcase
        end
    end

    // Handshake and session state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            mode_reg       <= psc_pkg::MODE_CLOSED;
            deadline_reg   <= '0;
            commit_reg     <= '0;
            success_reg    <= '0;
            retry_reg      <= '0;
            fail_cnt_reg   <= '0;
            snap_reg       <= '0;
            submitted_reg  <= 1'b0;
            claim_done_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (step)
            begin
                in_vld_reg <= 1'b0;
            end

            if (step)
            begin
                out_vld_reg    <= 1'b1;
                mode_reg       <= mode_next;
                deadline_reg   <= deadline_next;
                commit_reg     <= commit_next;
                success_reg    <= success_next;
                retry_reg      <= retry_next;
                fail_cnt_reg   <= fail_cnt_next;
                snap_reg       <= snap_next;
                submitted_reg  <= submitted_next;
                claim_done_reg <= claim_done_next;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg   <= s_tuser;
            now_reg    <= s_tdata[TIME_BITS-1:0];
            ready_reg  <= s_tdata[RDY_B];
            ap_reg     <= s_tdata[AP_B];
            online_reg <= s_tdata[ONL_B];
            rej_reg    <= s_tdata[REJ_LO +: psc_pkg::REJ_W];
            ok_reg     <= s_tdata[OK_B];
        end
        if (step)
        begin
            act_reg       <= act_next;
            mode_code_reg <= psc_pkg::mode_code(mode_next);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/psc_checker.sv =====
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the provisioning session controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module psc_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [psc_pkg::OUT_W-1:0]  m_tdata
);

    logic [2:0] act;
    logic [2:0] md;

    assign act = m_tdata[2:0];
    assign md  = m_tdata[5:3];

    `PSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_tvalid, "result word valid during reset")

    // With no result word pending, the input side can never be stalled.
    `PSC_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

    `PSC_ASSERT(a_word_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result word changed")

    // A session start or step action always lands in the matching mode.
    `PSC_ASSERT(a_action_mode, m_tvalid && act != psc_pkg::ACT_NONE && act != psc_pkg::ACT_STOP |-> act == md, "action and mode disagree")

    `PSC_ASSERT(a_stop_mode, m_tvalid && act == psc_pkg::ACT_STOP |-> md == psc_pkg::MC_CLOSED || md == psc_pkg::MC_LOCKED || md == psc_pkg::MC_ERROR, "stop action in an active mode")

endmodule

bind provisioning_session_controller psc_checker u_psc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
